@@ rtl/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and codes for the literal type classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ClassW = 3;

	typedef logic [CharW-1:0]  char_t;
	typedef logic [ClassW-1:0] class_code_t;

	typedef enum logic [ClassW-1:0] {
		CLS_BINARY = 3'd0,
		CLS_MONEY  = 3'd1,
		CLS_FLOAT  = 3'd2,
		CLS_INT    = 3'd3,
		CLS_CHAR   = 3'd4
	} cls_t;

	localparam char_t ChSpace  = 8'h20;
	localparam char_t ChTab    = 8'h09;
	localparam char_t ChCr     = 8'h0d;
	localparam char_t ChZero   = 8'h30;
	localparam char_t ChNine   = 8'h39;
	localparam char_t ChPlus   = 8'h2b;
	localparam char_t ChMinus  = 8'h2d;
	localparam char_t ChDollar = 8'h24;
	localparam char_t ChX      = 8'h78;
	localparam char_t ChPoint  = 8'h2e;
	localparam char_t ChLowE   = 8'h65;
	localparam char_t ChUpE    = 8'h45;
	localparam char_t ChLowA   = 8'h61;
	localparam char_t ChLowF   = 8'h66;
	localparam char_t ChUpA    = 8'h41;
	localparam char_t ChUpF    = 8'h46;

	// decoded attributes of one character
	typedef struct packed {
		logic ws;
		logic dig;
		logic zero;
		logic sign;
		logic hexd;
		logic dollar;
		logic x;
		logic point;
		logic expo;
	} char_attr_t;

endpackage

@@ rtl/ltc_char_if.sv @@
// ----------------------------------------------------------------------------
// ltc_char_if
// Character stream channel: one byte of a token per transfer.
// ----------------------------------------------------------------------------
interface ltc_char_if
	import ltc_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t char_code;
	logic  last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/ltc_class_if.sv @@
// ----------------------------------------------------------------------------
// ltc_class_if
// Result channel: one token class per transfer.
// ----------------------------------------------------------------------------
interface ltc_class_if
	import ltc_pkg::*;
();
	logic        valid;
	logic        ready;
	class_code_t token_class;

	modport source (output valid, output token_class, input ready);
	modport sink   (input valid, input token_class, output ready);
endinterface

@@ rtl/ltc_char_decode.sv @@
// ----------------------------------------------------------------------------
// ltc_char_decode
// Decodes one byte into the character attributes the recognizers test.
// ----------------------------------------------------------------------------
module ltc_char_decode
	import ltc_pkg::*;
(
	input  char_t      char_code,
	output char_attr_t attr
);

	logic dig;

	assign dig = (char_code >= ChZero) && (char_code <= ChNine);

	always_comb begin
		attr.ws     = (char_code == ChSpace) || ((char_code >= ChTab) && (char_code <= ChCr));
		attr.dig    = dig;
		attr.zero   = (char_code == ChZero);
		attr.sign   = (char_code == ChPlus) || (char_code == ChMinus);
		attr.hexd   = dig || ((char_code >= ChLowA) && (char_code <= ChLowF))
			|| ((char_code >= ChUpA) && (char_code <= ChUpF));
		attr.dollar = (char_code == ChDollar);
		attr.x      = (char_code == ChX);
		attr.point  = (char_code == ChPoint);
		attr.expo   = (char_code == ChLowE) || (char_code == ChUpE);
	end

endmodule

@@ rtl/ltc_recog.sv @@
// ----------------------------------------------------------------------------
// ltc_recog
// Four token recognizers running side by side, plus the priority pick of
// the token class from their next states.
// ----------------------------------------------------------------------------
module ltc_recog
	import ltc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  char_attr_t attr,
	output cls_t       cls
);

	typedef enum logic [4:0] {
		HX_LEAD  = 5'b00001,
		HX_ZERO  = 5'b00010,
		HX_BODY  = 5'b00100,
		HX_TRAIL = 5'b01000,
		HX_FAIL  = 5'b10000
	} hex_st_t;

	typedef enum logic [5:0] {
		MY_LEAD   = 6'b000001,
		MY_SIGN   = 6'b000010,
		MY_DOLLAR = 6'b000100,
		MY_BODY   = 6'b001000,
		MY_TRAIL  = 6'b010000,
		MY_FAIL   = 6'b100000
	} money_st_t;

	typedef enum logic [9:0] {
		FL_LEAD  = 10'b0000000001,
		FL_SIGN  = 10'b0000000010,
		FL_INT   = 10'b0000000100,
		FL_POINT = 10'b0000001000,
		FL_FRAC  = 10'b0000010000,
		FL_EXP   = 10'b0000100000,
		FL_ESIGN = 10'b0001000000,
		FL_EDIG  = 10'b0010000000,
		FL_TRAIL = 10'b0100000000,
		FL_FAIL  = 10'b1000000000
	} float_st_t;

	typedef enum logic [4:0] {
		IN_LEAD  = 5'b00001,
		IN_SIGN  = 5'b00010,
		IN_DIG   = 5'b00100,
		IN_TRAIL = 5'b01000,
		IN_FAIL  = 5'b10000
	} int_st_t;

	hex_st_t   hex_q,   hex_d;
	money_st_t money_q, money_d;
	float_st_t float_q, float_d;
	int_st_t   int_q,   int_d;

	always_comb begin
		case (hex_q)
			HX_LEAD:  hex_d = attr.ws ? HX_LEAD : (attr.zero ? HX_ZERO : HX_FAIL);
			HX_ZERO:  hex_d = attr.x ? HX_BODY : HX_FAIL;
			HX_BODY:  hex_d = attr.hexd ? HX_BODY : (attr.ws ? HX_TRAIL : HX_FAIL);
			HX_TRAIL: hex_d = attr.ws ? HX_TRAIL : HX_FAIL;
			default:  hex_d = HX_FAIL;
		endcase
	end

	always_comb begin
		case (money_q)
			MY_LEAD: begin
				if (attr.ws)          money_d = MY_LEAD;
				else if (attr.sign)   money_d = MY_SIGN;
				else if (attr.dollar) money_d = MY_DOLLAR;
				else                  money_d = MY_FAIL;
			end
			MY_SIGN: money_d = attr.dollar ? MY_DOLLAR : MY_FAIL;
			// the second sign is allowed only right after the '$'
			MY_DOLLAR: begin
				if (attr.sign || attr.dig || attr.point) money_d = MY_BODY;
				else if (attr.ws)                        money_d = MY_TRAIL;
				else                                     money_d = MY_FAIL;
			end
			MY_BODY: begin
				if (attr.dig || attr.point) money_d = MY_BODY;
				else if (attr.ws)           money_d = MY_TRAIL;
				else                        money_d = MY_FAIL;
			end
			MY_TRAIL: money_d = attr.ws ? MY_TRAIL : MY_FAIL;
			default:  money_d = MY_FAIL;
		endcase
	end

	always_comb begin
		case (float_q)
			FL_LEAD: begin
				if (attr.ws)        float_d = FL_LEAD;
				else if (attr.sign) float_d = FL_SIGN;
				else if (attr.dig)  float_d = FL_INT;
				else                float_d = FL_FAIL;
			end
			FL_SIGN: float_d = attr.dig ? FL_INT : FL_FAIL;
			FL_INT: begin
				if (attr.dig)        float_d = FL_INT;
				else if (attr.point) float_d = FL_POINT;
				else if (attr.expo)  float_d = FL_EXP;
				else                 float_d = FL_FAIL;
			end
			FL_POINT: float_d = attr.dig ? FL_FRAC : FL_FAIL;
			FL_FRAC: begin
				if (attr.dig)       float_d = FL_FRAC;
				else if (attr.expo) float_d = FL_EXP;
				else if (attr.ws)   float_d = FL_TRAIL;
				else                float_d = FL_FAIL;
			end
			FL_EXP: begin
				if (attr.sign)     float_d = FL_ESIGN;
				else if (attr.dig) float_d = FL_EDIG;
				else               float_d = FL_FAIL;
			end
			FL_ESIGN: float_d = attr.dig ? FL_EDIG : FL_FAIL;
			FL_EDIG: begin
				if (attr.dig)     float_d = FL_EDIG;
				else if (attr.ws) float_d = FL_TRAIL;
				else              float_d = FL_FAIL;
			end
			FL_TRAIL: float_d = attr.ws ? FL_TRAIL : FL_FAIL;
			default:  float_d = FL_FAIL;
		endcase
	end

	always_comb begin
		case (int_q)
			IN_LEAD: begin
				if (attr.ws)        int_d = IN_LEAD;
				else if (attr.sign) int_d = IN_SIGN;
				else if (attr.dig)  int_d = IN_DIG;
				else                int_d = IN_FAIL;
			end
			IN_SIGN:  int_d = attr.dig ? IN_DIG : IN_FAIL;
			IN_DIG:   int_d = attr.dig ? IN_DIG : (attr.ws ? IN_TRAIL : IN_FAIL);
			IN_TRAIL: int_d = attr.ws ? IN_TRAIL : IN_FAIL;
			default:  int_d = IN_FAIL;
		endcase
	end

	always_comb begin
		if (hex_d == HX_BODY || hex_d == HX_TRAIL)
			cls = CLS_BINARY;
		else if (money_d == MY_DOLLAR || money_d == MY_BODY || money_d == MY_TRAIL)
			cls = CLS_MONEY;
		else if (float_d == FL_FRAC || float_d == FL_EDIG || float_d == FL_TRAIL)
			cls = CLS_FLOAT;
		else if (int_d == IN_DIG || int_d == IN_TRAIL)
			cls = CLS_INT;
		else
			cls = CLS_CHAR;
	end

	// back to the start states once the token's last byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_q   <= HX_LEAD;
			money_q <= MY_LEAD;
			float_q <= FL_LEAD;
			int_q   <= IN_LEAD;
		end else if (step) begin
			if (last) begin
				hex_q   <= HX_LEAD;
				money_q <= MY_LEAD;
				float_q <= FL_LEAD;
				int_q   <= IN_LEAD;
			end else begin
				hex_q   <= hex_d;
				money_q <= money_d;
				float_q <= float_d;
				int_q   <= int_d;
			end
		end
	end

endmodule

@@ rtl/literal_type_classifier.sv @@
// ----------------------------------------------------------------------------
// literal_type_classifier
// Classifies a text token, one byte per transfer, as hex binary, money,
// float, int or plain character string.
//
//   channel   dir   payload                 transfer when
//   chars     in    char_code, last_char    valid && ready
//   result    out   token_class             valid && ready
//
// One byte per cycle, sustained, while a stalled result holds no last byte.
// A byte is held in the input register; the recognizer states are updated
// from it as it moves on, and a class reaches result through the class register
// as the token's last byte moves on. Reset puts all recognizers at their start
// state and empties both registers. A stalled result holds only bytes that end
// a token; other bytes keep flowing into the recognizers behind it.
// ----------------------------------------------------------------------------
module literal_type_classifier
	import ltc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ltc_char_if.sink    chars,
	ltc_class_if.source result
);

	logic        valid_s1;
	char_t       char_s1;
	logic        last_s1;
	logic        advance;
	logic        out_valid_q;
	class_code_t class_q;
	char_attr_t  attr;
	cls_t        cls;

	// a last byte may move only if the result register frees up
	assign advance      = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign chars.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	ltc_char_decode u_decode (
		.char_code (char_s1),
		.attr      (attr)
	);

	ltc_recog u_recog (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.last   (last_s1),
		.attr   (attr),
		.cls    (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			class_q <= class_code_t'(cls);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.token_class = class_q;

endmodule
